### rtl/iida_pkg.sv
// Shared types and constants for the indexed insert/delete array.
`timescale 1ns / 1ps
`default_nettype none

package iida_pkg;

  // Storage geometry.
  localparam int unsigned DEPTH     = 256;
  localparam int unsigned WORD_BITS = 32;
  localparam int unsigned ADDR_W    = $clog2(DEPTH);
  localparam int unsigned CNT_W     = $clog2(DEPTH + 1);

  // Port field widths.
  localparam int unsigned OPC_W     = 2;
  localparam int unsigned POS_W     = 9;
  localparam int unsigned DATA_W    = 32;
  localparam int unsigned STAT_W    = 2;
  localparam int unsigned OUT_CNT_W = 9;

  localparam int unsigned STORE_W = (WORD_BITS < DATA_W) ? WORD_BITS : DATA_W;
  localparam int unsigned CMP_W   = (POS_W > CNT_W) ? POS_W : CNT_W;

  typedef enum logic [OPC_W-1:0] {
    OP_INSERT = 2'd0,
    OP_REMOVE = 2'd1,
    OP_GET    = 2'd2,
    OP_SET    = 2'd3
  } opcode_e;

  typedef enum logic [STAT_W-1:0] {
    ST_OK    = 2'd0,
    ST_RANGE = 2'd1,
    ST_FULL  = 2'd2,
    ST_EMPTY = 2'd3
  } status_e;

  typedef enum logic [1:0] {
    K_INS = 2'd0,
    K_REM = 2'd1,
    K_GET = 2'd2,
    K_REP = 2'd3
  } kind_e;

  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_MOVE = 5'b00010,
    S_WAIT = 5'b00100,
    S_PUT  = 5'b01000,
    S_FIN  = 5'b10000
  } state_e;

  // Decoded checks on an incoming transaction against the current size.
  typedef struct packed {
    status_e           status;
    logic              append;
    logic              replace;
    logic              rem_last;
    logic [ADDR_W-1:0] last_addr;
  } chk_t;

  // Size update request issued when an operation completes.
  typedef struct packed {
    logic grow;
    logic shrink;
  } upd_t;

endpackage

`default_nettype wire

### rtl/iida_ram.sv
// Single-port-write, single-port-read synchronous RAM with registered read data.
`timescale 1ns / 1ps
`default_nettype none

module iida_ram #(
  parameter int unsigned Depth = 256,
  parameter int unsigned Width = 32
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] waddr_i,
  input  wire logic [Width-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(Depth)-1:0] raddr_i,
  output logic      [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_o <= mem[raddr_i];
    end
  end

endmodule

`default_nettype wire

### rtl/iida_size.sv
// Entry count and logical capacity bookkeeping, with index and size checks.
`timescale 1ns / 1ps
`default_nettype none

module iida_size import iida_pkg::*; (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic [OPC_W-1:0] opcode_i,
  input  wire logic [POS_W-1:0] position_i,
  input  wire upd_t             upd_i,
  output chk_t                  chk_o,
  output logic      [CNT_W-1:0] count_o,
  output logic      [CNT_W-1:0] cap_o,
  output logic      [CNT_W-1:0] cnt_next_o,
  output logic      [CNT_W-1:0] cap_next_o
);

  logic [CNT_W-1:0] count_q, count_d;
  logic [CNT_W-1:0] cap_q, cap_d;

  always_comb begin
    logic [CMP_W-1:0] pos_x;
    logic [CMP_W-1:0] cnt_x;
    logic             full;
    pos_x = CMP_W'(position_i);
    cnt_x = CMP_W'(count_q);
    full  = (count_q == CNT_W'(DEPTH));

    chk_o.status    = ST_OK;
    chk_o.append    = 1'b0;
    chk_o.replace   = 1'b0;
    chk_o.rem_last  = 1'b0;
    chk_o.last_addr = ADDR_W'(count_q - CNT_W'(1));

    unique case (opcode_e'(opcode_i))
      OP_INSERT: begin
        priority if (pos_x > cnt_x) begin
          chk_o.status = ST_RANGE;
        end else if (full) begin
          chk_o.status = ST_FULL;
        end else begin
          chk_o.append = 1'b1;
        end
      end
      OP_REMOVE: begin
        priority if (count_q == '0) begin
          chk_o.status = ST_EMPTY;
        end else if (pos_x > cnt_x) begin
          chk_o.status = ST_RANGE;
        end else begin
          chk_o.rem_last = (pos_x == cnt_x);
        end
      end
      OP_GET: begin
        if (pos_x >= cnt_x) begin
          chk_o.status = ST_RANGE;
        end
      end
      OP_SET: begin
        priority if (pos_x < cnt_x) begin
          chk_o.replace = 1'b1;
        end else if (pos_x > cnt_x) begin
          chk_o.status = ST_RANGE;
        end else if (full) begin
          chk_o.status = ST_FULL;
        end else begin
          chk_o.append = 1'b1;
        end
      end
      default: begin
        chk_o.status = ST_OK;
      end
    endcase
  end

  // Capacity doubles on an insert into a full list (saturating at the depth),
  // halves when the count falls below a quarter of it, and drops to one when empty.
  always_comb begin
    logic [CNT_W:0]   dbl;
    logic [CNT_W+1:0] cnt_x4;
    dbl    = {cap_q, 1'b0};
    cnt_x4 = '0;
    count_d = count_q;
    cap_d   = cap_q;
    if (upd_i.grow) begin
      count_d = count_q + CNT_W'(1);
      if (count_q == cap_q) begin
        cap_d = (dbl > (CNT_W + 1)'(DEPTH)) ? CNT_W'(DEPTH) : dbl[CNT_W-1:0];
      end
    end else if (upd_i.shrink) begin
      count_d = count_q - CNT_W'(1);
      cnt_x4  = {count_d, 2'b00};
      if (count_d == '0) begin
        cap_d = CNT_W'(1);
      end else if (cnt_x4 < (CNT_W + 2)'(cap_q)) begin
        cap_d = cap_q >> 1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      cap_q   <= CNT_W'(1);
    end else if (upd_i.grow || upd_i.shrink) begin
      count_q <= count_d;
      cap_q   <= cap_d;
    end
  end

  assign count_o    = count_q;
  assign cap_o      = cap_q;
  assign cnt_next_o = count_d;
  assign cap_next_o = cap_d;

endmodule

`default_nettype wire

### rtl/indexed_insert_delete_array_top.sv
// Top level of the indexed insert/delete array: sequencer around the entry RAM.
`timescale 1ns / 1ps
`default_nettype none

// Ordered list of up to DEPTH words held in one synchronous RAM.
// A transaction is accepted at a rising edge where start_i is high and busy_o
// is low; opcode_i, position_i and data_word_i are sampled there. Exactly one
// result follows per transaction: done_o is high for one cycle with the result
// fields, and the receiver cannot hold it off.
// Sequence of states from the accepting edge to the result:
//   rejected transaction (range, full, empty): no state is entered, busy_o stays low.
//   get, remove of the last entry: S_WAIT, S_FIN; insert or set at the end: S_PUT, S_FIN.
//   set of an existing entry: S_WAIT, S_PUT, S_FIN.
//   insert at position p below the count: S_MOVE for each entry from count - 1 down to p, then S_WAIT, S_PUT, S_FIN.
//   remove at position p: S_MOVE for each entry from p + 1 up to count - 1, then S_WAIT, S_FIN.
// Shifting moves one entry per cycle, limited by the single RAM read and write
// port; reads and writes of neighboring entries are overlapped. A new
// transaction may be accepted in the cycle in which done_o is shown.
// Reset clears the count to 0 and the capacity to 1; the RAM contents are not
// cleared, and only entries below the count are ever read.
module indexed_insert_delete_array_top import iida_pkg::*; (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 start_i,
  output logic                      busy_o,
  input  wire logic [OPC_W-1:0]     opcode_i,
  input  wire logic [POS_W-1:0]     position_i,
  input  wire logic [DATA_W-1:0]    data_word_i,
  output logic                      done_o,
  output logic      [DATA_W-1:0]    read_word_o,
  output logic      [STAT_W-1:0]    status_o,
  output logic                      replaced_o,
  output logic      [OUT_CNT_W-1:0] count_after_o,
  output logic      [OUT_CNT_W-1:0] capacity_after_o
);

  state_e            state_q, state_d;
  kind_e             kind_q, kind_d;
  logic [ADDR_W-1:0] pos_q, pos_d;
  logic [STORE_W-1:0] w_q, w_d;
  logic [ADDR_W-1:0] src_q, src_d;
  logic [ADDR_W-1:0] last_q, last_d;
  logic [ADDR_W-1:0] prev_q, prev_d;
  logic              rv_q, rv_d;
  logic              rcap_q, rcap_d;
  logic [STORE_W-1:0] rd_q, rd_d;

  logic                 res_valid_q, res_valid_d;
  logic [STORE_W-1:0]   res_word_q, res_word_d;
  status_e              res_status_q, res_status_d;
  logic                 res_rep_q, res_rep_d;
  logic [OUT_CNT_W-1:0] res_cnt_q, res_cnt_d;
  logic [OUT_CNT_W-1:0] res_cap_q, res_cap_d;

  logic               ram_we, ram_re;
  logic [ADDR_W-1:0]  ram_waddr, ram_raddr;
  logic [STORE_W-1:0] ram_wdata, ram_rdata;

  chk_t             chk;
  upd_t             upd;
  logic [CNT_W-1:0] count, cap, cnt_next, cap_next;
  logic             accept;

  assign busy_o = (state_q != S_IDLE);
  assign accept = start_i && !busy_o;

  iida_size u_size (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .opcode_i   (opcode_i),
    .position_i (position_i),
    .upd_i      (upd),
    .chk_o      (chk),
    .count_o    (count),
    .cap_o      (cap),
    .cnt_next_o (cnt_next),
    .cap_next_o (cap_next)
  );

  iida_ram #(
    .Depth (DEPTH),
    .Width (STORE_W)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  always_comb begin
    logic [ADDR_W-1:0] rem_pos;
    rem_pos = chk.rem_last ? chk.last_addr : position_i[ADDR_W-1:0];

    state_d = state_q;
    kind_d  = kind_q;
    pos_d   = pos_q;
    w_d     = w_q;
    src_d   = src_q;
    last_d  = last_q;
    prev_d  = prev_q;
    rv_d    = 1'b0;
    rcap_d  = rcap_q;
    rd_d    = rd_q;

    res_valid_d  = 1'b0;
    res_word_d   = res_word_q;
    res_status_d = res_status_q;
    res_rep_d    = res_rep_q;
    res_cnt_d    = res_cnt_q;
    res_cap_d    = res_cap_q;

    ram_re    = 1'b0;
    ram_raddr = src_q;
    ram_we    = 1'b0;
    ram_waddr = (kind_q == K_INS) ? (prev_q + ADDR_W'(1)) : (prev_q - ADDR_W'(1));
    ram_wdata = ram_rdata;

    upd.grow   = 1'b0;
    upd.shrink = 1'b0;

    // Data read in the previous cycle is either the word to return or an
    // entry moving one place toward its new index.
    if (rv_q) begin
      if (rcap_q) begin
        rd_d = ram_rdata;
      end else begin
        ram_we = 1'b1;
      end
    end

    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          pos_d = position_i[ADDR_W-1:0];
          w_d   = data_word_i[STORE_W-1:0];
          if (chk.status != ST_OK) begin
            res_valid_d  = 1'b1;
            res_word_d   = '0;
            res_status_d = chk.status;
            res_rep_d    = 1'b0;
            res_cnt_d    = OUT_CNT_W'(count);
            res_cap_d    = OUT_CNT_W'(cap);
          end else if (chk.append) begin
            kind_d = K_INS;
            rd_d   = '0;
            if (CMP_W'(position_i) == CMP_W'(count)) begin
              state_d = S_PUT;
            end else begin
              src_d   = chk.last_addr;
              last_d  = position_i[ADDR_W-1:0];
              state_d = S_MOVE;
            end
          end else if (opcode_e'(opcode_i) == OP_REMOVE) begin
            kind_d    = K_REM;
            ram_re    = 1'b1;
            ram_raddr = rem_pos;
            rv_d      = 1'b1;
            rcap_d    = 1'b1;
            if (rem_pos == chk.last_addr) begin
              state_d = S_WAIT;
            end else begin
              src_d   = rem_pos + ADDR_W'(1);
              last_d  = chk.last_addr;
              state_d = S_MOVE;
            end
          end else begin
            kind_d    = chk.replace ? K_REP : K_GET;
            ram_re    = 1'b1;
            ram_raddr = position_i[ADDR_W-1:0];
            rv_d      = 1'b1;
            rcap_d    = 1'b1;
            state_d   = S_WAIT;
          end
        end
      end
      S_MOVE: begin
        ram_re    = 1'b1;
        ram_raddr = src_q;
        rv_d      = 1'b1;
        rcap_d    = 1'b0;
        prev_d    = src_q;
        if (src_q == last_q) begin
          state_d = S_WAIT;
        end else begin
          src_d = (kind_q == K_INS) ? (src_q - ADDR_W'(1)) : (src_q + ADDR_W'(1));
        end
      end
      S_WAIT: begin
        state_d = ((kind_q == K_INS) || (kind_q == K_REP)) ? S_PUT : S_FIN;
      end
      S_PUT: begin
        ram_we    = 1'b1;
        ram_waddr = pos_q;
        ram_wdata = w_q;
        state_d   = S_FIN;
      end
      S_FIN: begin
        upd.grow     = (kind_q == K_INS);
        upd.shrink   = (kind_q == K_REM);
        res_valid_d  = 1'b1;
        res_word_d   = rd_q;
        res_status_d = ST_OK;
        res_rep_d    = (kind_q == K_REP);
        res_cnt_d    = OUT_CNT_W'(cnt_next);
        res_cap_d    = OUT_CNT_W'(cap_next);
        state_d      = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      rv_q        <= 1'b0;
      rcap_q      <= 1'b0;
      res_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      rv_q        <= rv_d;
      rcap_q      <= rcap_d;
      res_valid_q <= res_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    kind_q       <= kind_d;
    pos_q        <= pos_d;
    w_q          <= w_d;
    src_q        <= src_d;
    last_q       <= last_d;
    prev_q       <= prev_d;
    rd_q         <= rd_d;
    res_word_q   <= res_word_d;
    res_status_q <= res_status_d;
    res_rep_q    <= res_rep_d;
    res_cnt_q    <= res_cnt_d;
    res_cap_q    <= res_cap_d;
  end

  assign done_o           = res_valid_q;
  assign read_word_o      = DATA_W'(res_word_q);
  assign status_o         = res_status_q;
  assign replaced_o       = res_rep_q;
  assign count_after_o    = res_cnt_q;
  assign capacity_after_o = res_cap_q;

  // A result appears only after a completed operation or a rejected transaction.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(state_q == S_FIN || (accept && chk.status != ST_OK)))
    else $error("result strobe without a finishing operation");

  // Overlapped shifting must never read and write the same entry in one cycle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ram_we && ram_re) |-> (ram_waddr != ram_raddr))
    else $error("RAM read and write collide on one entry");

  // The logical capacity always covers the entries held, within the depth.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (count <= cap) && (cap <= CNT_W'(DEPTH)) && (cap != '0))
    else $error("count or capacity out of bounds");

  // A full rejection is only given when every entry is in use.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && chk.status == ST_FULL) |-> (count == CNT_W'(DEPTH)))
    else $error("full reported while space remains");

endmodule

`default_nettype wire
